@@ src/tvsm_pkg.sv @@
// Shared types and constants for the tracked vehicle steering mixer.
// Holds the vehicle mode codes, register indexes and the stage payload structs.
// No dependencies.
`default_nettype none

package tvsm_pkg;

  localparam int STICK_W    = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_HALF   = 2'd1,
    MODE_FULL   = 2'd2,
    MODE_THRUST = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_VEHICLE_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BATTERY_CHECK = 1'd1;

  // after the dead band: raw left/right factors and signed speed
  typedef struct packed {
    logic [STICK_W-1:0] fl;
    logic [STICK_W-1:0] fr;
    logic signed [8:0]  speed;
    logic               cut;
    mode_t              mode;
  } s1_t;

  // after the curve
  typedef struct packed {
    logic signed [7:0] fl2;
    logic signed [7:0] fr2;
    logic signed [8:0] speed;
    logic              cut;
  } s2_t;

  // speed times curved factor, per track
  typedef struct packed {
    logic signed [15:0] pa;
    logic signed [15:0] pb;
    logic               cut;
  } s3_t;

endpackage

`default_nettype wire

@@ src/tvsm_factor.sv @@
// First stage: dead band split of the steering stick into left/right factors,
// throttle clamp and signed speed. Depends on tvsm_pkg.
`default_nettype none

module tvsm_factor (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [tvsm_pkg::STICK_W-1:0] steering,
  input  wire logic [tvsm_pkg::STICK_W-1:0] throttle,
  input  wire logic                       battery_ok,
  input  wire tvsm_pkg::mode_t            mode,
  input  wire logic                       battery_check_enable,
  output logic                            s1_valid,
  output tvsm_pkg::s1_t                   s1
);
  import tvsm_pkg::*;

  localparam int DEAD_LOW  = 48;
  localparam int DEAD_HIGH = 52;
  localparam int FULL      = 100;
  localparam int RECIP_SH  = 16;
  // 100/48 as a fixed-point reciprocal, rounded up so the floor stays exact
  localparam int FACT_K    = (FULL * (1 << RECIP_SH) + DEAD_LOW - 1) / DEAD_LOW;
  localparam int HIGH_SPAN = FULL - DEAD_HIGH;
  localparam int FACT_KR   = (FULL * (1 << RECIP_SH) + HIGH_SPAN - 1) / HIGH_SPAN;

  logic [24:0]        prod_l;
  logic [24:0]        prod_r;
  logic [STICK_W-1:0] dist_r;
  logic [STICK_W-1:0] thr_c;
  s1_t                s1_nxt;
  s1_t                s1_r;
  logic               v1_r;

  always_comb begin
    dist_r = STICK_W'(FULL) - steering;
    prod_l = 25'(steering) * 25'(FACT_K);
    prod_r = 25'(dist_r) * 25'(FACT_KR);

    s1_nxt = '0;
    if (steering <= STICK_W'(DEAD_LOW)) begin
      s1_nxt.fl = prod_l[RECIP_SH +: STICK_W];
    end else begin
      s1_nxt.fl = STICK_W'(FULL);
    end

    if (steering > STICK_W'(FULL)) begin
      s1_nxt.fr = '0;
    end else if (steering >= STICK_W'(DEAD_HIGH)) begin
      s1_nxt.fr = prod_r[RECIP_SH +: STICK_W];
    end else begin
      s1_nxt.fr = STICK_W'(FULL);
    end

    // thrust mode keeps the throttle in the forward half
    thr_c = throttle;
    if (mode == MODE_THRUST) begin
      if (throttle < STICK_W'(50)) begin
        thr_c = STICK_W'(50);
      end else if (throttle > STICK_W'(FULL)) begin
        thr_c = STICK_W'(FULL);
      end
    end

    s1_nxt.speed = 9'sd100 - $signed({1'b0, thr_c, 1'b0});
    s1_nxt.cut   = ~battery_ok & battery_check_enable;
    s1_nxt.mode  = mode;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  assign s1_valid = v1_r;
  assign s1       = s1_r;

endmodule

`default_nettype wire

@@ src/tvsm_curve.sv @@
// Second stage: five-point curve on both factors, chosen by vehicle mode.
// Segment slopes are divided out by fixed-point reciprocals. Depends on tvsm_pkg.
`default_nettype none

module tvsm_curve (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          s1_valid,
  input  wire tvsm_pkg::s1_t s1,
  output logic               s2_valid,
  output tvsm_pkg::s2_t      s2
);
  import tvsm_pkg::*;

  localparam int SH  = 16;
  localparam int K25 = ((1 << SH) + 24) / 25;
  localparam int K7  = ((1 << SH) + 6) / 7;
  localparam int K13 = ((1 << SH) + 12) / 13;
  localparam int K40 = ((1 << SH) + 39) / 40;

  // slope times reciprocal, one per segment kind
  localparam logic [19:0] C_HALF   = 20'(10 * K25);
  localparam logic [19:0] C_THRUST = 20'(20 * K25);
  localparam logic [19:0] C_FULL0  = 20'(100 * K7);
  localparam logic [19:0] C_FULL1  = 20'(45 * K13);
  localparam logic [19:0] C_FULL2  = 20'(40 * K40);
  localparam logic [19:0] C_FULL3  = 20'(15 * K40);

  function automatic logic signed [7:0] curve_map(mode_t m, logic [STICK_W-1:0] x);
    logic [5:0]        t;
    logic [19:0]       c;
    logic signed [7:0] base;
    logic              neg;
    logic [25:0]       prod;
    logic [7:0]        q;
    t    = '0;
    c    = '0;
    base = '0;
    neg  = 1'b0;
    case (m)
      MODE_HALF, MODE_THRUST: begin
        c = (m == MODE_HALF) ? C_HALF : C_THRUST;
        if (x <= STICK_W'(25)) begin
          t    = 6'(x);
          base = (m == MODE_HALF) ? 8'sd60 : 8'sd20;
        end else if (x <= STICK_W'(50)) begin
          t    = 6'(x - STICK_W'(25));
          base = (m == MODE_HALF) ? 8'sd70 : 8'sd40;
        end else if (x <= STICK_W'(75)) begin
          t    = 6'(x - STICK_W'(50));
          base = (m == MODE_HALF) ? 8'sd80 : 8'sd60;
        end else begin
          t    = 6'(x - STICK_W'(75));
          base = (m == MODE_HALF) ? 8'sd90 : 8'sd80;
        end
      end
      MODE_FULL: begin
        if (x <= STICK_W'(7)) begin
          // negative part: measure back from the zero crossing so it truncates toward zero
          t   = 6'(STICK_W'(7) - x);
          c   = C_FULL0;
          neg = 1'b1;
        end else if (x <= STICK_W'(20)) begin
          t = 6'(x - STICK_W'(7));
          c = C_FULL1;
        end else if (x <= STICK_W'(60)) begin
          t    = 6'(x - STICK_W'(20));
          c    = C_FULL2;
          base = 8'sd45;
        end else begin
          t    = 6'(x - STICK_W'(60));
          c    = C_FULL3;
          base = 8'sd85;
        end
      end
      default: begin
        c = '0;
      end
    endcase
    prod = 26'(t) * 26'(c);
    q    = prod[SH +: 8];
    if (neg) begin
      return base - $signed(q);
    end
    return base + $signed(q);
  endfunction

  s2_t  s2_nxt;
  s2_t  s2_r;
  logic v2_r;

  always_comb begin
    s2_nxt.fl2   = curve_map(s1.mode, s1.fl);
    s2_nxt.fr2   = curve_map(s1.mode, s1.fr);
    s2_nxt.speed = s1.speed;
    s2_nxt.cut   = s1.cut;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

  assign s2_valid = v2_r;
  assign s2       = s2_r;

endmodule

`default_nettype wire

@@ src/tvsm_drive.sv @@
// Third and fourth stages: speed times curved factor, then divide by 100,
// map back to 0..100, battery cut-off and driving flag. Depends on tvsm_pkg.
`default_nettype none

module tvsm_drive (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         s2_valid,
  input  wire tvsm_pkg::s2_t                s2,
  output logic                              out_valid,
  output logic [tvsm_pkg::STICK_W-1:0]      motor_a_cmd,
  output logic [tvsm_pkg::STICK_W-1:0]      motor_b_cmd,
  output logic                              driving
);
  import tvsm_pkg::*;

  localparam int DIV_SH = 20;
  localparam int DIV_K  = ((1 << DIV_SH) + 99) / 100;

  // trunc(x / 100) toward zero, then trunc((p - 100) / 2) + 100, clamped
  function automatic logic [STICK_W-1:0] to_cmd(logic signed [15:0] x);
    logic              neg;
    logic [15:0]       ax;
    logic [28:0]       prod;
    logic [7:0]        q;
    logic signed [9:0] p;
    logic signed [9:0] cmd;
    neg  = x[15];
    ax   = neg ? 16'(-x) : x;
    prod = 29'(ax[14:0]) * 29'(DIV_K);
    q    = prod[DIV_SH +: 8];
    p    = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    if (p <= 10'sd100) begin
      cmd = 10'sd100 - ((10'sd100 - p) >>> 1);
    end else begin
      cmd = 10'sd100 + ((p - 10'sd100) >>> 1);
    end
    if (cmd < 10'sd0) begin
      return '0;
    end else if (cmd > 10'sd100) begin
      return STICK_W'(100);
    end
    return cmd[STICK_W-1:0];
  endfunction

  logic signed [16:0]  mul_a;
  logic signed [16:0]  mul_b;
  s3_t                 s3_nxt;
  s3_t                 s3_r;
  logic                v3_r;
  logic [STICK_W-1:0]  a_nxt;
  logic [STICK_W-1:0]  b_nxt;
  logic                drv_nxt;
  logic [STICK_W-1:0]  a_r;
  logic [STICK_W-1:0]  b_r;
  logic                drv_r;
  logic                v4_r;

  always_comb begin
    mul_a      = 17'(s2.speed) * 17'(s2.fr2);
    mul_b      = 17'(s2.speed) * 17'(s2.fl2);
    s3_nxt.pa  = mul_a[15:0];
    s3_nxt.pb  = mul_b[15:0];
    s3_nxt.cut = s2.cut;
  end

  always_comb begin
    if (s3_r.cut) begin
      a_nxt = '0;
      b_nxt = '0;
    end else begin
      a_nxt = to_cmd(s3_r.pa);
      b_nxt = to_cmd(s3_r.pb);
    end
    drv_nxt = (a_nxt < STICK_W'(40)) || (a_nxt > STICK_W'(60)) ||
              (b_nxt < STICK_W'(40)) || (b_nxt > STICK_W'(60));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v3_r <= s2_valid;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_r  <= s3_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    drv_r <= drv_nxt;
  end

  assign out_valid   = v4_r;
  assign motor_a_cmd = a_r;
  assign motor_b_cmd = b_r;
  assign driving     = drv_r;

endmodule

`default_nettype wire

@@ src/tracked_vehicle_steering_mixer_top.sv @@
// Top level of the tracked vehicle steering mixer: configuration registers and
// the four-stage mixing pipeline. Depends on tvsm_pkg, tvsm_factor, tvsm_curve, tvsm_drive.
//
// Usage:
//   Input: present steering, throttle and battery_ok with start high; the beat
//   is taken at a rising edge where start is high and busy is low. busy is low
//   whenever the block is out of reset, so one beat can be taken every cycle.
//   Output: each result is shown for exactly one cycle with out_valid high;
//   the receiver cannot stall, so results are never held back.
//   Pipeline: a beat taken at a rising edge passes the four register stages
//   (factors, curve, multiply, divide and map) in that order before it is
//   shown. Throughput is one beat per cycle.
//   Configuration: write vehicle_mode (index 0) or battery_check_enable
//   (index 1) through cfg_valid/cfg_ready/cfg_index/cfg_data while no beat is
//   in flight. cfg_ready is always high.
//   Reset: synchronous, active low; clears the pipeline valid bits, sets
//   vehicle_mode to no curve and enables the battery check. busy stays high
//   while reset is held.
`default_nettype none

module tracked_vehicle_steering_mixer_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [tvsm_pkg::STICK_W-1:0]     in_steering,
  input  wire logic [tvsm_pkg::STICK_W-1:0]     in_throttle,
  input  wire logic                             in_battery_ok,
  output logic                                  out_valid,
  output logic [tvsm_pkg::STICK_W-1:0]          out_motor_a_cmd,
  output logic [tvsm_pkg::STICK_W-1:0]          out_motor_b_cmd,
  output logic                                  out_driving,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tvsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tvsm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tvsm_pkg::*;

  mode_t vehicle_mode_r;
  logic  battery_check_enable_r;
  logic  busy_r;
  logic  in_fire;
  logic  s1_valid;
  s1_t   s1;
  logic  s2_valid;
  s2_t   s2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vehicle_mode_r         <= MODE_NONE;
      battery_check_enable_r <= 1'b1;
      busy_r                 <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VEHICLE_MODE:  vehicle_mode_r         <= mode_t'(cfg_data[1:0]);
          REG_BATTERY_CHECK: battery_check_enable_r <= cfg_data[0];
          default: begin
            vehicle_mode_r <= vehicle_mode_r;
          end
        endcase
      end
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign in_fire   = start & ~busy_r;

  tvsm_factor u_factor (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_fire),
    .steering             (in_steering),
    .throttle             (in_throttle),
    .battery_ok           (in_battery_ok),
    .mode                 (vehicle_mode_r),
    .battery_check_enable (battery_check_enable_r),
    .s1_valid             (s1_valid),
    .s1                   (s1)
  );

  tvsm_curve u_curve (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  tvsm_drive u_drive (
    .clk         (clk),
    .rst_n       (rst_n),
    .s2_valid    (s2_valid),
    .s2          (s2),
    .out_valid   (out_valid),
    .motor_a_cmd (out_motor_a_cmd),
    .motor_b_cmd (out_motor_b_cmd),
    .driving     (out_driving)
  );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking bench for tracked_vehicle_steering_mixer_top: queued stick beats,
// an in-bench predictor of both track commands, and a strobe monitor.
// Depends on tvsm_pkg and the mixer RTL only.
`timescale 1ns / 1ps

module tb;
  import tvsm_pkg::*;

  localparam int DEAD_LO  = 48;
  localparam int DEAD_HI  = 52;
  localparam int IDLE_MAX = 1000;

  typedef struct {
    logic [STICK_W-1:0] steering;
    logic [STICK_W-1:0] throttle;
    logic               battery_ok;
  } stick_beat_t;

  typedef struct {
    logic [STICK_W-1:0] motor_a;
    logic [STICK_W-1:0] motor_b;
    logic               driving;
  } track_cmd_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [STICK_W-1:0] in_steering = '0;
  logic [STICK_W-1:0] in_throttle = '0;
  logic in_battery_ok = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic busy, out_valid, out_driving, cfg_ready;
  logic [STICK_W-1:0] out_motor_a_cmd, out_motor_b_cmd;

  stick_beat_t stick_beats_q[$];
  track_cmd_t  track_cmd_q[$];
  mode_t       cur_mode = MODE_NONE;
  bit          cur_batt_chk = 1'b1;
  bit          no_idle = 1'b0;
  int          gap_left = 0;
  int          err_count = 0;
  int          idle_cycles = 0;

  tracked_vehicle_steering_mixer_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_steering     (in_steering),
    .in_throttle     (in_throttle),
    .in_battery_ok   (in_battery_ok),
    .out_valid       (out_valid),
    .out_motor_a_cmd (out_motor_a_cmd),
    .out_motor_b_cmd (out_motor_b_cmd),
    .out_driving     (out_driving),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // piecewise-linear reshaping of a 0..100 factor, whole quotient truncated
  function automatic int shape_factor(mode_t m, int x);
    int kx[5];
    int ky[5];
    int dx;
    case (m)
      MODE_HALF: begin
        kx = '{0, 25, 50, 75, 100};
        ky = '{60, 70, 80, 90, 100};
      end
      MODE_FULL: begin
        kx = '{0, 7, 20, 60, 100};
        ky = '{-100, 0, 45, 85, 100};
      end
      default: begin
        kx = '{0, 25, 50, 75, 100};
        ky = '{20, 40, 60, 80, 100};
      end
    endcase
    if (x <= kx[0]) return ky[0];
    for (int k = 0; k < 4; k++) begin
      if (x <= kx[k+1]) begin
        dx = kx[k+1] - kx[k];
        return (ky[k] * dx + (x - kx[k]) * (ky[k+1] - ky[k])) / dx;
      end
    end
    return ky[4];
  endfunction

  function automatic int track_command(int speed, int factor);
    int p;
    p = speed * factor / 100;
    return clip((p - 100) * (-100) / (-200) + 100, 0, 100);
  endfunction

  function automatic track_cmd_t mix_tracks(stick_beat_t s);
    int st, th, fl, fr, fl2, fr2, speed, a, b;
    track_cmd_t r;
    st = int'(s.steering);
    th = int'(s.throttle);
    fl = (st <= DEAD_LO) ? clip(st * 100 / DEAD_LO, 0, 100) : 100;
    fr = (st >= DEAD_HI) ? clip((st - 100) * 100 / (DEAD_HI - 100), 0, 100) : 100;
    if (st > 100) fr = 0;
    fl2 = 0;
    fr2 = 0;
    if (cur_mode != MODE_NONE) begin
      fl2 = shape_factor(cur_mode, fl);
      fr2 = shape_factor(cur_mode, fr);
    end
    if (cur_mode == MODE_THRUST) th = clip(th, 50, 100);
    speed = 100 - 2 * th;
    a = track_command(speed, fr2);
    b = track_command(speed, fl2);
    if (!s.battery_ok && cur_batt_chk) begin
      a = 0;
      b = 0;
    end
    r.motor_a = a[STICK_W-1:0];
    r.motor_b = b[STICK_W-1:0];
    r.driving = (a < 40 || a > 60 || b < 40 || b > 60);
    return r;
  endfunction

  function automatic int next_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_mismatch(string what);
    $display("%0t MISMATCH %s", $realtime, what);
    err_count++;
  endtask

  // driver: present the next queued stick beat, predict on acceptance
  always @(posedge clk) begin
    if (start && !busy) track_cmd_q.push_back(mix_tracks('{in_steering, in_throttle,
                                                            in_battery_ok}));
    if (start && busy) begin
      // hold the beat until taken
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (stick_beats_q.size() > 0) begin
      stick_beat_t nb;
      nb = stick_beats_q.pop_front();
      in_steering   <= nb.steering;
      in_throttle   <= nb.throttle;
      in_battery_ok <= nb.battery_ok;
      start <= 1'b1;
      gap_left = next_gap();
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: results cannot be stalled, check each strobe against the oldest prediction
  always @(posedge clk) begin
    if (out_valid === 1'b1) begin
      if (track_cmd_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result a=%0d b=%0d drv=%0b",
                                out_motor_a_cmd, out_motor_b_cmd, out_driving));
      end else begin
        track_cmd_t e;
        e = track_cmd_q.pop_front();
        if (out_motor_a_cmd !== e.motor_a)
          flag_mismatch($sformatf("motor_a_cmd got %0d exp %0d", out_motor_a_cmd, e.motor_a));
        if (out_motor_b_cmd !== e.motor_b)
          flag_mismatch($sformatf("motor_b_cmd got %0d exp %0d", out_motor_b_cmd, e.motor_b));
        if (out_driving !== e.driving)
          flag_mismatch($sformatf("driving got %0b exp %0b", out_driving, e.driving));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid === 1'b1 || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == REG_VEHICLE_MODE) cur_mode = mode_t'(val);
    else cur_batt_chk = val[0];
  endtask

  task automatic set_config(mode_t m, bit chk);
    logic [CFG_DATA_W-1:0] d;
    write_reg(REG_VEHICLE_MODE, m);
    // upper data bit is don't-care for the battery check
    d = {1'($urandom_range(0, 1)), chk};
    write_reg(REG_BATTERY_CHECK, d);
  endtask

  task automatic push_beat(int st, int th, bit bat);
    stick_beats_q.push_back('{st[STICK_W-1:0], th[STICK_W-1:0], bat});
  endtask

  task automatic push_random(int n);
    int r, st, th;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 10) st = $urandom_range(101, 127);
      else if (r < 30) st = $urandom_range(44, 56);
      else if (r < 38) st = (r < 34) ? 0 : 100;
      else st = $urandom_range(0, 100);
      r = $urandom_range(0, 99);
      if (r < 10) th = $urandom_range(101, 127);
      else if (r < 25) th = (r < 18) ? 0 : 100;
      else if (r < 35) th = $urandom_range(45, 55);
      else th = $urandom_range(0, 100);
      push_beat(st, th, $urandom_range(0, 9) != 0);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (stick_beats_q.size() != 0 || start || track_cmd_q.size() != 0);
  endtask

  initial begin
    mode_t mode_seq[4];
    mode_t m;
    bit chk;
    mode_seq = '{MODE_NONE, MODE_HALF, MODE_FULL, MODE_THRUST};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: no curve, battery check on
    push_beat(50, 50, 1'b1);
    push_beat(0, 100, 1'b1);
    push_beat(127, 0, 1'b0);
    wait_drained();

    set_config(MODE_FULL, 1'b0);
    push_beat(0, 0, 1'b1);
    push_beat(100, 100, 1'b1);
    push_beat(48, 0, 1'b1);
    push_beat(49, 100, 1'b1);
    push_beat(51, 0, 1'b1);
    push_beat(52, 100, 1'b1);
    push_beat(101, 0, 1'b1);
    push_beat(127, 127, 1'b0);
    push_beat(3, 20, 1'b1);
    push_beat(70, 80, 1'b1);
    wait_drained();

    set_config(MODE_THRUST, 1'b1);
    push_beat(0, 0, 1'b1);
    push_beat(100, 30, 1'b1);
    push_beat(25, 127, 1'b1);
    push_beat(75, 100, 1'b0);
    push_beat(50, 49, 1'b1);
    wait_drained();

    set_config(MODE_HALF, 1'b1);
    push_beat(0, 127, 1'b1);
    push_beat(100, 0, 1'b1);
    push_beat(120, 60, 1'b1);
    push_beat(60, 0, 1'b0);
    wait_drained();

    for (int k = 0; k < 12; k++) begin
      if (k < 4) begin
        m = mode_seq[k];
        chk = k[0];
      end else begin
        m = mode_seq[$urandom_range(0, 3)];
        chk = $urandom_range(0, 1);
      end
      set_config(m, chk);
      no_idle = ($urandom_range(0, 3) == 0);
      push_random($urandom_range(120, 210));
      wait_drained();
    end

    // let any stray strobes surface before the verdict
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
